/* sv/tdps_pkg.sv */
`default_nettype none

package tdps_pkg;

    localparam int XY_W  = 16;
    localparam int Z_W   = 32;
    localparam int DXY_W = 17;
    localparam int DZ_W  = 33;
    localparam int PRD_W = 50;
    localparam int NRM_W = 51;
    localparam int K_W   = 35;
    localparam int SUM_W = 70;
    localparam int NUM_W = 70;
    localparam int DEN_W = 35;
    localparam int OUT_W = 48;
    localparam int FRAC_SHIFT = 4;
    localparam int LANES = 3;

    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;

    typedef struct packed {
        logic signed [XY_W-1:0] x0;
        logic signed [XY_W-1:0] y0;
        logic signed [Z_W-1:0]  z0;
        logic signed [XY_W-1:0] x1;
        logic signed [XY_W-1:0] y1;
        logic signed [Z_W-1:0]  z1;
        logic signed [XY_W-1:0] x2;
        logic signed [XY_W-1:0] y2;
        logic signed [Z_W-1:0]  z2;
    } t_tri;

    typedef struct packed {
        logic signed [XY_W-1:0]  x0;
        logic signed [XY_W-1:0]  y0;
        logic signed [Z_W-1:0]   z0;
        logic signed [NRM_W-1:0] ni;
        logic signed [NRM_W-1:0] nj;
        logic signed [K_W-1:0]   nk;
    } t_normal;

    typedef struct packed {
        logic             degen;
        logic [LANES-1:0] neg;
    } t_side;

    function automatic logic signed [OUT_W-1:0] sat_quo(input logic [NUM_W-1:0] quo,
                                                        input logic neg);
        logic [NUM_W-1:0] lim;
        lim = NUM_W'(1) << (OUT_W - 1);
        if (!neg) begin
            lim = lim - NUM_W'(1);
        end
        if (quo > lim) begin
            sat_quo = neg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else begin
            sat_quo = neg ? -quo[OUT_W-1:0] : quo[OUT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/tdps_if.sv */
`default_nettype none

interface tdps_vtx_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [31:0] first_z;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic signed [31:0] second_z;
    logic signed [15:0] third_x;
    logic signed [15:0] third_y;
    logic signed [31:0] third_z;

    modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                   third_x, third_y, third_z, input ready);
    modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                 third_x, third_y, third_z, output ready);
endinterface

interface tdps_pln_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] plane_offset;
    logic signed [47:0] depth_step_x;
    logic signed [47:0] depth_step_y;
    logic        degenerate;

    modport source(output valid, plane_offset, depth_step_x, depth_step_y, degenerate,
                   input ready);
    modport sink(input valid, plane_offset, depth_step_x, depth_step_y, degenerate,
                 output ready);
endinterface

`default_nettype wire

/* sv/tdps_cross.sv */
`default_nettype none

module tdps_cross (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire tdps_pkg::t_tri    i_tri,
    output logic                   o_vld,
    output tdps_pkg::t_normal      o_nrm
);

    logic                                r_vld1, r_vld2, r_vld3;
    logic signed [tdps_pkg::DXY_W-1:0]   r_ax, r_ay, r_bx, r_by;
    logic signed [tdps_pkg::DZ_W-1:0]    r_az, r_bz;
    logic signed [tdps_pkg::XY_W-1:0]    r_x0_1, r_y0_1, r_x0_2, r_y0_2;
    logic signed [tdps_pkg::Z_W-1:0]     r_z0_1, r_z0_2;
    logic signed [tdps_pkg::PRD_W-1:0]   r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    tdps_pkg::t_normal                   r_nrm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax   <= tdps_pkg::DXY_W'(i_tri.x1) - tdps_pkg::DXY_W'(i_tri.x0);
            r_ay   <= tdps_pkg::DXY_W'(i_tri.y1) - tdps_pkg::DXY_W'(i_tri.y0);
            r_az   <= tdps_pkg::DZ_W'(i_tri.z1) - tdps_pkg::DZ_W'(i_tri.z0);
            r_bx   <= tdps_pkg::DXY_W'(i_tri.x2) - tdps_pkg::DXY_W'(i_tri.x0);
            r_by   <= tdps_pkg::DXY_W'(i_tri.y2) - tdps_pkg::DXY_W'(i_tri.y0);
            r_bz   <= tdps_pkg::DZ_W'(i_tri.z2) - tdps_pkg::DZ_W'(i_tri.z0);
            r_x0_1 <= i_tri.x0;
            r_y0_1 <= i_tri.y0;
            r_z0_1 <= i_tri.z0;

            r_p1   <= r_ay * r_bz;
            r_p2   <= r_az * r_by;
            r_p3   <= r_az * r_bx;
            r_p4   <= r_ax * r_bz;
            r_p5   <= r_ax * r_by;
            r_p6   <= r_ay * r_bx;
            r_x0_2 <= r_x0_1;
            r_y0_2 <= r_y0_1;
            r_z0_2 <= r_z0_1;

            r_nrm.ni <= tdps_pkg::NRM_W'(r_p1) - tdps_pkg::NRM_W'(r_p2);
            r_nrm.nj <= tdps_pkg::NRM_W'(r_p3) - tdps_pkg::NRM_W'(r_p4);
            r_nrm.nk <= tdps_pkg::K_W'(r_p5) - tdps_pkg::K_W'(r_p6);
            r_nrm.x0 <= r_x0_2;
            r_nrm.y0 <= r_y0_2;
            r_nrm.z0 <= r_z0_2;
        end
    end

    assign o_vld = r_vld3;
    assign o_nrm = r_nrm;

endmodule

`default_nettype wire

/* sv/tdps_num.sv */
`default_nettype none

module tdps_num (
    input  wire logic                                              i_clk,
    input  wire logic                                              i_rst_n,
    input  wire logic                                              i_en,
    input  wire logic                                              i_vld,
    input  wire tdps_pkg::t_normal                                 i_nrm,
    output logic                                                   o_vld,
    output logic [tdps_pkg::LANES-1:0][tdps_pkg::NUM_W-1:0]        o_num,
    output logic [tdps_pkg::DEN_W-1:0]                             o_den,
    output tdps_pkg::t_side                                        o_side
);

    localparam int PAD_W = tdps_pkg::NUM_W - tdps_pkg::NRM_W - tdps_pkg::FRAC_SHIFT;

    logic                                r_vld4, r_vld5, r_vld6;
    logic signed [tdps_pkg::SUM_W-1:0]   r_q0, r_q1, r_q2, r_sum;
    logic [tdps_pkg::NUM_W-1:0]          r_mag_a4, r_mag_b4, r_mag_a5, r_mag_b5;
    logic [tdps_pkg::DEN_W-1:0]          r_den4, r_den5;
    logic                                r_degen4, r_degen5;
    logic                                r_neg_a4, r_neg_b4, r_neg_a5, r_neg_b5;
    logic                                r_kneg4, r_kneg5;
    logic [tdps_pkg::LANES-1:0][tdps_pkg::NUM_W-1:0] r_num;
    logic [tdps_pkg::DEN_W-1:0]          r_den;
    tdps_pkg::t_side                     r_side;

    logic [tdps_pkg::NRM_W-1:0]          n_mag_ni, n_mag_nj;
    logic [tdps_pkg::DEN_W-1:0]          n_mag_nk;
    logic                                n_ni_pos, n_nj_pos, n_kneg;
    logic [tdps_pkg::NUM_W-1:0]          n_mag_c;

    always_comb begin
        n_mag_ni = i_nrm.ni[tdps_pkg::NRM_W-1] ? -i_nrm.ni : i_nrm.ni;
        n_mag_nj = i_nrm.nj[tdps_pkg::NRM_W-1] ? -i_nrm.nj : i_nrm.nj;
        n_mag_nk = i_nrm.nk[tdps_pkg::K_W-1] ? -i_nrm.nk : i_nrm.nk;
        n_ni_pos = !i_nrm.ni[tdps_pkg::NRM_W-1] && (|i_nrm.ni);
        n_nj_pos = !i_nrm.nj[tdps_pkg::NRM_W-1] && (|i_nrm.nj);
        n_kneg   = i_nrm.nk[tdps_pkg::K_W-1];
        n_mag_c  = r_sum[tdps_pkg::SUM_W-1] ? -r_sum : r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld4 <= i_vld;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0     <= i_nrm.x0 * i_nrm.ni;
            r_q1     <= i_nrm.y0 * i_nrm.nj;
            r_q2     <= i_nrm.z0 * i_nrm.nk;
            r_mag_a4 <= {{PAD_W{1'b0}}, n_mag_ni, {tdps_pkg::FRAC_SHIFT{1'b0}}};
            r_mag_b4 <= {{PAD_W{1'b0}}, n_mag_nj, {tdps_pkg::FRAC_SHIFT{1'b0}}};
            r_den4   <= n_mag_nk;
            r_degen4 <= (i_nrm.nk == '0);
            r_neg_a4 <= n_ni_pos ^ n_kneg;
            r_neg_b4 <= n_nj_pos ^ n_kneg;
            r_kneg4  <= n_kneg;

            r_sum    <= r_q0 + r_q1 + r_q2;
            r_mag_a5 <= r_mag_a4;
            r_mag_b5 <= r_mag_b4;
            r_den5   <= r_den4;
            r_degen5 <= r_degen4;
            r_neg_a5 <= r_neg_a4;
            r_neg_b5 <= r_neg_b4;
            r_kneg5  <= r_kneg4;

            r_num[tdps_pkg::LANE_A]      <= r_mag_a5;
            r_num[tdps_pkg::LANE_B]      <= r_mag_b5;
            r_num[tdps_pkg::LANE_C]      <= n_mag_c;
            r_den                        <= r_den5;
            r_side.degen                 <= r_degen5;
            r_side.neg[tdps_pkg::LANE_A] <= r_neg_a5;
            r_side.neg[tdps_pkg::LANE_B] <= r_neg_b5;
            r_side.neg[tdps_pkg::LANE_C] <= r_sum[tdps_pkg::SUM_W-1] ^ r_kneg5;
        end
    end

    assign o_vld  = r_vld6;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_side = r_side;

endmodule

`default_nettype wire

/* sv/tdps_div.sv */
`default_nettype none

module tdps_div #(
    parameter int NUM_W = 70,
    parameter int DEN_W = 35,
    parameter int TAG_W = 4,
    parameter int LANES = 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_vld,
    input  wire logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]             i_den,
    input  wire logic [TAG_W-1:0]             i_tag,
    output logic                              o_vld,
    output logic [LANES-1:0][NUM_W-1:0]       o_quo,
    output logic [TAG_W-1:0]                  o_tag
);

    logic                             r_vld [NUM_W];
    logic [DEN_W-1:0]                 r_den [NUM_W];
    logic [TAG_W-1:0]                 r_tag [NUM_W];
    logic [LANES-1:0][DEN_W-1:0]      r_rem [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]      r_num [NUM_W];
    logic [LANES-1:0][NUM_W-1:0]      r_quo [NUM_W];

    for (genvar s = 0; s < NUM_W; s++) begin : g_stage
        logic                         w_vld;
        logic [DEN_W-1:0]             w_den;
        logic [TAG_W-1:0]             w_tag;
        logic [LANES-1:0][DEN_W-1:0]  w_rem;
        logic [LANES-1:0][NUM_W-1:0]  w_num;
        logic [LANES-1:0][NUM_W-1:0]  w_quo;
        logic [LANES-1:0][DEN_W-1:0]  n_rem;
        logic [LANES-1:0][NUM_W-1:0]  n_num;
        logic [LANES-1:0][NUM_W-1:0]  n_quo;

        if (s == 0) begin : g_first
            assign w_vld = i_vld;
            assign w_den = i_den;
            assign w_tag = i_tag;
            assign w_rem = '0;
            assign w_num = i_num;
            assign w_quo = '0;
        end else begin : g_next
            assign w_vld = r_vld[s-1];
            assign w_den = r_den[s-1];
            assign w_tag = r_tag[s-1];
            assign w_rem = r_rem[s-1];
            assign w_num = r_num[s-1];
            assign w_quo = r_quo[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DEN_W:0] w_try;
            logic           w_ge;
            assign w_try    = {w_rem[l], w_num[l][NUM_W-1]};
            assign w_ge     = (w_try >= {1'b0, w_den});
            assign n_rem[l] = w_ge ? DEN_W'(w_try - {1'b0, w_den}) : w_try[DEN_W-1:0];
            assign n_num[l] = {w_num[l][NUM_W-2:0], 1'b0};
            assign n_quo[l] = {w_quo[l][NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= w_den;
                r_tag[s] <= w_tag;
                r_rem[s] <= n_rem;
                r_num[s] <= n_num;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_vld = r_vld[NUM_W-1];
    assign o_quo = r_quo[NUM_W-1];
    assign o_tag = r_tag[NUM_W-1];

endmodule

`default_nettype wire

/* sv/triangle_depth_plane_setup.sv */
`default_nettype none

// Depth plane setup: takes one triangle per clock unless stalled and returns c, dz/dx and
// dz/dy of its plane, saturated signed 48-bit (c Q48.0, dz/dx and dz/dy Q44.4). Edge vectors
// and the normal take three stages, the numerators three more, then a 70-stage restoring
// divider (one quotient bit per stage, three lanes sharing |k|) and an output register.
// A stall on the output holds the whole pipeline; nothing is dropped or repeated.
module triangle_depth_plane_setup (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tdps_vtx_if.sink    i_vtx,
    tdps_pln_if.source  o_pln
);

    localparam int TAG_W = $bits(tdps_pkg::t_side);

    logic                                                    w_en;
    tdps_pkg::t_tri                                          w_tri;
    logic                                                    w_nrm_vld;
    tdps_pkg::t_normal                                       w_nrm;
    logic                                                    w_num_vld;
    logic [tdps_pkg::LANES-1:0][tdps_pkg::NUM_W-1:0]         w_num;
    logic [tdps_pkg::DEN_W-1:0]                              w_den;
    tdps_pkg::t_side                                         w_side;
    logic                                                    w_div_vld;
    logic [tdps_pkg::LANES-1:0][tdps_pkg::NUM_W-1:0]         w_quo;
    logic [TAG_W-1:0]                                        w_div_tag;
    tdps_pkg::t_side                                         w_div_side;

    logic                                r_out_vld;
    logic signed [tdps_pkg::OUT_W-1:0]   r_off, r_stx, r_sty;
    logic                                r_degen;

    assign w_en = !r_out_vld || o_pln.ready;
    assign i_vtx.ready = w_en;

    assign w_tri.x0 = i_vtx.first_x;
    assign w_tri.y0 = i_vtx.first_y;
    assign w_tri.z0 = i_vtx.first_z;
    assign w_tri.x1 = i_vtx.second_x;
    assign w_tri.y1 = i_vtx.second_y;
    assign w_tri.z1 = i_vtx.second_z;
    assign w_tri.x2 = i_vtx.third_x;
    assign w_tri.y2 = i_vtx.third_y;
    assign w_tri.z2 = i_vtx.third_z;

    tdps_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_vtx.valid),
        .i_tri   (w_tri),
        .o_vld   (w_nrm_vld),
        .o_nrm   (w_nrm)
    );

    tdps_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_nrm_vld),
        .i_nrm   (w_nrm),
        .o_vld   (w_num_vld),
        .o_num   (w_num),
        .o_den   (w_den),
        .o_side  (w_side)
    );

    tdps_div #(
        .NUM_W (tdps_pkg::NUM_W),
        .DEN_W (tdps_pkg::DEN_W),
        .TAG_W (TAG_W),
        .LANES (tdps_pkg::LANES)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_num_vld),
        .i_num   (w_num),
        .i_den   (w_den),
        .i_tag   (w_side),
        .o_vld   (w_div_vld),
        .o_quo   (w_quo),
        .o_tag   (w_div_tag)
    );

    assign w_div_side = w_div_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_degen <= w_div_side.degen;
            if (w_div_side.degen) begin
                r_off <= '0;
                r_stx <= '0;
                r_sty <= '0;
            end else begin
                r_off <= tdps_pkg::sat_quo(w_quo[tdps_pkg::LANE_C],
                                           w_div_side.neg[tdps_pkg::LANE_C]);
                r_stx <= tdps_pkg::sat_quo(w_quo[tdps_pkg::LANE_A],
                                           w_div_side.neg[tdps_pkg::LANE_A]);
                r_sty <= tdps_pkg::sat_quo(w_quo[tdps_pkg::LANE_B],
                                           w_div_side.neg[tdps_pkg::LANE_B]);
            end
        end
    end

    assign o_pln.valid        = r_out_vld;
    assign o_pln.plane_offset = r_off;
    assign o_pln.depth_step_x = r_stx;
    assign o_pln.depth_step_y = r_sty;
    assign o_pln.degenerate   = r_degen;

endmodule

`default_nettype wire
